// File: rtl/base64_stream_encoder_assert.svh
// Assertion macros shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Checked only while the block is out of reset.
`define B64SE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define B64SE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/b64se_pkg.sv
package b64se_pkg;

  // Width of one Base64 code.
  localparam int unsigned CodeW = 6;
  // Width of one ASCII character on the result channel.
  localparam int unsigned CharW = 7;

  // Codes that depend on the alphabet choice.
  localparam logic [CodeW-1:0] CodePlus  = 6'd62;
  localparam logic [CodeW-1:0] CodeSlash = 6'd63;

  // One encoded byte: one or two codes waiting to be sent.
  typedef struct packed {
    logic [CodeW-1:0] code0;
    logic [CodeW-1:0] code1;
    logic             two;
    logic             fin;
  } item_t;

  // Maps a 6-bit code to its ASCII character.
  function automatic logic [CharW-1:0] code_to_char(input logic [CodeW-1:0] code,
                                                   input logic url_safe);
    logic [CharW-1:0] ch;
    if (code < 6'd26) begin
      ch = 7'h41 + {1'b0, code};
    end else if (code < 6'd52) begin
      ch = 7'h61 + {1'b0, code - 6'd26};
    end else if (code < CodePlus) begin
      ch = 7'h30 + {1'b0, code - 6'd52};
    end else if (code == CodePlus) begin
      ch = url_safe ? 7'h2D : 7'h2B;
    end else begin
      ch = url_safe ? 7'h5F : 7'h2F;
    end
    return ch;
  endfunction

endpackage

// File: rtl/b64se_pack.sv
`include "base64_stream_encoder_assert.svh"

module b64se_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             is_final_i,
  input  logic             pop_last_i,
  output logic             item_valid_o,
  output b64se_pkg::item_t item_o
);

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       carry_q, carry_d;
  logic             item_valid_q, item_valid_d;
  b64se_pkg::item_t item_q, item_d;
  logic             accept;

  // The item register frees up in the same cycle its last code leaves.
  assign in_stall_o   = item_valid_q && !pop_last_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign item_valid_d = accept || (item_valid_q && !pop_last_i);

  // Split the byte into codes according to the group position.
  always_comb begin
    item_d.fin = is_final_i;
    case (phase_q)
      PH_1: begin
        item_d.code0 = {carry_q[1:0], in_byte_i[7:4]};
        item_d.code1 = {in_byte_i[3:0], 2'b00};
        item_d.two   = is_final_i;
        carry_d      = in_byte_i[3:0];
        phase_d      = PH_2;
      end
      PH_2: begin
        item_d.code0 = {carry_q, in_byte_i[7:6]};
        item_d.code1 = in_byte_i[5:0];
        item_d.two   = 1'b1;
        carry_d      = 4'd0;
        phase_d      = PH_0;
      end
      default: begin
        item_d.code0 = in_byte_i[7:2];
        item_d.code1 = {in_byte_i[1:0], 4'b0000};
        item_d.two   = is_final_i;
        carry_d      = {2'b00, in_byte_i[1:0]};
        phase_d      = PH_1;
      end
    endcase
    // A final byte closes the encoding.
    if (is_final_i) begin
      carry_d = 4'd0;
      phase_d = PH_0;
    end
  end

  // Group state and the control bit of the item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_0;
      carry_q      <= 4'd0;
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        carry_q <= carry_d;
      end
    end
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

  `B64SE_ASSERT(a_stall_needs_item, in_stall_o |-> item_valid_q, "stall without a held item")
  `B64SE_ASSERT(a_final_resets_group, accept && is_final_i |=> phase_q == PH_0 && carry_q == 4'd0, "group not closed after final byte")

endmodule

// File: rtl/b64se_out.sv
`include "base64_stream_encoder_assert.svh"

module b64se_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            url_safe_i,
  input  logic                            item_valid_i,
  input  b64se_pkg::item_t                item_i,
  output logic                            pop_last_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [b64se_pkg::CharW-1:0]     out_char_o,
  output logic                            run_last_o,
  output logic                            text_last_o
);

  logic                        sel_q, sel_d;
  logic                        out_valid_q, out_valid_d;
  logic [b64se_pkg::CharW-1:0] out_char_q;
  logic                        run_last_q, text_last_q;
  logic                        load, take, last_code;
  logic [b64se_pkg::CodeW-1:0] code;

  // The result register takes a new word when empty or being drained.
  assign load        = !out_valid_q || !out_stall_i;
  assign take        = item_valid_i && load;
  assign code        = sel_q ? item_i.code1 : item_i.code0;
  assign last_code   = !item_i.two || sel_q;
  assign pop_last_o  = take && last_code;
  assign sel_d       = take ? !last_code : sel_q;
  assign out_valid_d = take || (out_valid_q && out_stall_i);

  // Control state of the result side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_char_q  <= b64se_pkg::code_to_char(code, url_safe_i);
      run_last_q  <= last_code;
      text_last_q <= last_code && item_i.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;
  assign text_last_o = text_last_q;

  `B64SE_ASSERT(a_second_code_held, sel_q |-> item_valid_i && out_valid_q && !run_last_q, "second code pending without its item")
  `B64SE_ASSERT(a_text_last_is_run_last, out_valid_q && text_last_q |-> run_last_q, "text end not at a byte end")
  `B64SE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q || rst_ni, "result valid right after reset")

endmodule

// File: rtl/base64_stream_encoder.sv
// Channel   | Handshake                      | Word
// ----------+--------------------------------+------------------------------------
// input     | in_valid_i / in_stall_o        | in_byte_i, is_final_i
// result    | out_valid_o / out_stall_i      | out_char_o, run_last_o, text_last_o
// config    | cfg_valid_i / cfg_ready_o      | cfg_url_safe_i
//
// The result register sends one character a cycle while the result is not
// stalled; a byte that yields two stalls the input until its second is taken.
// A byte's first character goes through the item and then the result register.
// Reset clears the group position, the alphabet choice and all valid bits.
// A stalled result holds its word; the input stalls while the held byte still
// has a character that the result register cannot take in this cycle.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       text_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_url_safe_i
);

  logic             url_safe_q;
  logic             item_valid;
  logic             pop_last;
  b64se_pkg::item_t item;

  // Alphabet selection register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_safe_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      url_safe_q <= cfg_url_safe_i;
    end
  end

  // Byte to code split with group state.
  b64se_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .is_final_i   (is_final_i),
    .pop_last_i   (pop_last),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Code to character serializer and result register.
  b64se_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .url_safe_i   (url_safe_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_last_o   (pop_last),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .text_last_o  (text_last_o)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;

  // Run length guard, in clock cycles.
  localparam int unsigned CycleLimit = 300000;
  // Cycles the receiver holds off during the backpressure phase.
  localparam int unsigned LongHold = 400;

  // Character tables, first character in the top byte.
  localparam logic [8*64-1:0] AlphaStd =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [8*64-1:0] AlphaUrl =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // Position of the next byte within its group of three.
  typedef enum logic [1:0] {
    GrpFirst  = 2'd0,
    GrpSecond = 2'd1,
    GrpThird  = 2'd2
  } grp_pos_e;

  // One input word waiting to be sent.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  // One result word.
  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       text_last;
  } b64_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       is_final_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] out_char_o;
  logic       run_last_o;
  logic       text_last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_url_safe_i = 1'b0;

  raw_byte_t   byte_pending_q[$];
  b64_char_t   char_expect_q[$];

  // Encoder state as predicted.
  grp_pos_e    grp_pos = GrpFirst;
  logic [3:0]  carry_bits = 4'h0;
  logic        url_mode = 1'b0;

  logic        byte_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned bytes_accepted = 0;
  int unsigned chars_checked = 0;
  int unsigned texts_ended = 0;
  int unsigned input_stall_cycles = 0;

  base64_stream_encoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .is_final_i     (is_final_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .run_last_o     (run_last_o),
    .text_last_o    (text_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_url_safe_i (cfg_url_safe_i)
  );

  always #6 clk_i = ~clk_i;

  // Looks up the character for a 6-bit code in the selected alphabet.
  function automatic logic [6:0] alphabet_char(input logic [5:0] code);
    logic [7:0] ch;
    if (url_mode) begin
      ch = AlphaUrl[8*(63-code) +: 8];
    end else begin
      ch = AlphaStd[8*(63-code) +: 8];
    end
    return ch[6:0];
  endfunction

  task automatic push_code(input logic [5:0] code, input logic rl, input logic tl);
    b64_char_t c;
    c.ch        = alphabet_char(code);
    c.run_last  = rl;
    c.text_last = tl;
    char_expect_q.push_back(c);
  endtask

  // Works out the characters one accepted byte produces and advances the state.
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    case (grp_pos)
      GrpSecond: begin
        push_code({carry_bits[1:0], b[7:4]}, !fin, 1'b0);
        if (fin) push_code({b[3:0], 2'b00}, 1'b1, 1'b1);
        carry_bits = b[3:0];
        grp_pos    = GrpThird;
      end
      GrpThird: begin
        push_code({carry_bits, b[7:6]}, 1'b0, 1'b0);
        push_code(b[5:0], 1'b1, fin);
        carry_bits = 4'h0;
        grp_pos    = GrpFirst;
      end
      default: begin
        push_code(b[7:2], !fin, 1'b0);
        if (fin) push_code({b[1:0], 4'b0000}, 1'b1, 1'b1);
        carry_bits = {2'b00, b[1:0]};
        grp_pos    = GrpSecond;
      end
    endcase
    if (fin) begin
      grp_pos    = GrpFirst;
      carry_bits = 4'h0;
    end
  endtask

  // Byte driver: presents the next pending word at the falling edge.
  always @(negedge clk_i) begin : drive_bytes
    raw_byte_t nxt;
    if (!in_valid_i || byte_taken) begin
      byte_taken = 1'b0;
      if (byte_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_pending_q.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i  <= nxt.data;
        is_final_i <= nxt.fin;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Input acceptance: predict the characters for each word taken.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i) begin
      if (!in_stall_o) begin
        predict_byte(in_byte_i, is_final_i);
        byte_taken = 1'b1;
        bytes_accepted++;
      end else begin
        input_stall_cycles++;
      end
    end
  end

  // Result stall driver, with a counted long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin : check_chars
    b64_char_t want;
    b64_char_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ch: out_char_o, run_last: run_last_o, text_last: text_last_o};
      if (char_expect_q.size() == 0) begin
        $display("%0t: unexpected word char=%h run_last=%b text_last=%b",
                 $time, got.ch, got.run_last, got.text_last);
        errors++;
      end else begin
        want = char_expect_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected char=%h run_last=%b text_last=%b",
                   $time, want.ch, want.run_last, want.text_last);
          $display("%0t:          actual   char=%h run_last=%b text_last=%b",
                   $time, got.ch, got.run_last, got.text_last);
          errors++;
        end
        chars_checked++;
        if (got.text_last) texts_ended++;
      end
    end
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic fin);
    byte_pending_q.push_back('{data: data, fin: fin});
  endtask

  // Writes the alphabet select; only called while the block is idle.
  task automatic set_alphabet(input logic url);
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_url_safe_i <= url;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    url_mode = url;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every word is sent and every expected character has arrived.
  task automatic wait_drained();
    @(posedge clk_i);
    while (byte_pending_q.size() != 0 || in_valid_i || char_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Queues random messages; a few carry random end flags as noise.
  task automatic add_messages(input int unsigned n_bytes);
    int unsigned added;
    int unsigned len;
    bit          noisy;
    added = 0;
    while (added < n_bytes) begin
      len   = $urandom_range(9, 1);
      noisy = ($urandom_range(99) < 15);
      for (int unsigned i = 0; i < len; i++) begin
        push_byte(8'($urandom_range(255)),
                  noisy ? 1'($urandom_range(1)) : (i == len - 1));
        added++;
      end
    end
  endtask

  task automatic run_random_phase(input logic url, input int unsigned send_pct,
                                  input int unsigned recv_pct, input int unsigned n_bytes);
    set_alphabet(url);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_messages(n_bytes);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: end flag at each group position, all-zero and all-one
    // bytes, and codes 62 and 63 in the standard alphabet.
    set_alphabet(1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b1);
    wait_drained();

    // Codes 62 and 63 in the URL-safe alphabet.
    set_alphabet(1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_drained();

    // Random phases with different idle and stall mixes.
    run_random_phase(1'b1, 0, 0, 150);
    run_random_phase(1'b0, 53, 0, 150);
    run_random_phase(1'b1, 0, 53, 150);
    run_random_phase(1'b0, 22, 22, 150);

    // Backpressure: the receiver holds off while the sender keeps offering.
    set_alphabet(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = LongHold;
    add_messages(50);
    wait_drained();

    $display("Run: %0d bytes accepted, %0d characters checked, %0d encodings closed.",
             bytes_accepted, chars_checked, texts_ended);
    $display("Both alphabets, mixed idle and stall rates, a %0d-cycle hold-off",
             LongHold);
    $display("and %0d input stall cycles.", input_stall_cycles);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
